// ===== hw/rtl/circular_deque_assert.svh =====
// Assertion macros shared by the circular deque RTL.
// Standalone header; it needs nothing from the package.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge outside of reset.
`define CDQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every clock edge, reset included.
`define CDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CDQ_ASSERT(label, clk, rst_n, prop, msg)
`define CDQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
// No dependencies; compiled before every other file of the block.
package cdq_pkg;

    localparam int unsigned DEPTH_DEF = 8;

    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch the accepted input beat
        logic exec;     // perform the operation on the stored queue
        logic capture;  // take the read data of a pop into the result
    } t_cdq_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_pending;  // the latched operation is a pop that will succeed
    } t_cdq_sts;

endpackage

// ===== hw/rtl/cdq_in_if.sv =====
// Input channel of the circular deque: valid/ready with opcode and push value.
// Depends on cdq_pkg for the field widths.
interface cdq_in_if;
    import cdq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [VALUE_W-1:0]  push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

// ===== hw/rtl/cdq_out_if.sv =====
// Result channel of the circular deque: valid/ready with status, value and count.
// Depends on cdq_pkg for the field widths.
interface cdq_out_if;
    import cdq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  pop_value;
    logic [COUNT_W-1:0]         entry_count;

    modport source (output valid, output status, output pop_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input pop_value, input entry_count,
                    output ready);
endinterface

// ===== hw/rtl/cdq_ctrl.sv =====
// Sequencing state machine of the circular deque.
// Depends on cdq_pkg and the assertion macros in circular_deque_assert.svh.
`include "circular_deque_assert.svh"

module cdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cdq_pkg::t_cdq_cmd o_cmd,
    input  cdq_pkg::t_cdq_sts i_sts
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN,
        S_SEND
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_comb begin
        o_cmd.load    = i_in_valid && r_in_ready;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.capture = (r_state == S_FIN);
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    // A successful pop passes through S_FIN for the registered read.
                    if (i_sts.pop_pending) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state     <= S_SEND;
                        r_out_valid <= 1'b1;
                    end
                end
                S_FIN: begin
                    r_state     <= S_SEND;
                    r_out_valid <= 1'b1;
                end
                S_SEND: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    `CDQ_ASSERT(a_ready_valid_excl, i_clk, i_rst_n, !(r_in_ready && r_out_valid), "input ready while a result is pending")
    `CDQ_ASSERT(a_load_to_exec, i_clk, i_rst_n, (i_in_valid && r_in_ready) |=> (r_state == S_EXEC), "accepted beat did not start execution")
    `CDQ_ASSERT(a_send_to_idle, i_clk, i_rst_n, (r_out_valid && i_out_ready) |=> (r_in_ready && !r_out_valid), "delivered result did not free the input")

endmodule

// ===== hw/rtl/cdq_dp.sv =====
// Datapath of the circular deque: entry store, wrapping indices, count and result register.
// Depends on cdq_pkg and the assertion macros in circular_deque_assert.svh.
`include "circular_deque_assert.svh"

module cdq_dp #(
    parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cdq_pkg::t_cdq_cmd                  i_cmd,
    output cdq_pkg::t_cdq_sts                  o_sts,
    input  logic [cdq_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic signed [cdq_pkg::VALUE_W-1:0] i_push_value,
    output logic [cdq_pkg::STATUS_W-1:0]       o_status,
    output logic signed [cdq_pkg::VALUE_W-1:0] o_pop_value,
    output logic [cdq_pkg::COUNT_W-1:0]        o_entry_count
);
    import cdq_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned EXT_W = CNT_W + COUNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_opcode                   r_op;
    logic signed [VALUE_W-1:0] r_val;
    logic [IDX_W-1:0]          r_front;
    logic [IDX_W-1:0]          r_rear;
    logic [CNT_W-1:0]          r_count;
    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rd_data;
    t_status                   r_status;
    logic signed [VALUE_W-1:0] r_pop_value;
    logic [COUNT_W-1:0]        r_out_count;

    logic [IDX_W-1:0] n_front;
    logic [IDX_W-1:0] n_rear;
    logic [CNT_W-1:0] n_count;
    t_status          n_status;
    logic [EXT_W-1:0] n_count_ext;

    logic             is_push;
    logic             is_empty;
    logic             is_full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] front_prev;
    logic [IDX_W-1:0] front_next;
    logic [IDX_W-1:0] rear_prev;
    logic [IDX_W-1:0] rear_next;

    assign is_push  = (r_op == OP_PUSH_REAR) || (r_op == OP_PUSH_FRONT);
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == FULL_CNT);

    assign front_next = (r_front == LAST_IDX) ? '0 : r_front + IDX_W'(1);
    assign front_prev = (r_front == '0) ? LAST_IDX : r_front - IDX_W'(1);
    assign rear_next  = (r_rear == LAST_IDX) ? '0 : r_rear + IDX_W'(1);
    assign rear_prev  = (r_rear == '0) ? LAST_IDX : r_rear - IDX_W'(1);

    assign rd_addr = (r_op == OP_POP_FRONT) ? r_front : r_rear;

    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_count  = r_count;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        wr_addr  = r_rear;
        if (is_push) begin
            if (is_full) begin
                n_status = ST_OVERFLOW;
            end else begin
                wr_en   = 1'b1;
                n_count = r_count + CNT_W'(1);
                if (is_empty) begin
                    // The first entry always lands at index zero.
                    n_front = '0;
                    n_rear  = '0;
                    wr_addr = '0;
                end else if (r_op == OP_PUSH_REAR) begin
                    n_rear  = rear_next;
                    wr_addr = rear_next;
                end else begin
                    n_front = front_prev;
                    wr_addr = front_prev;
                end
            end
        end else begin
            if (is_empty) begin
                n_status = ST_UNDERFLOW;
            end else begin
                n_count = r_count - CNT_W'(1);
                if (r_front == r_rear) begin
                    n_front = '0;
                    n_rear  = '0;
                end else if (r_op == OP_POP_FRONT) begin
                    n_front = front_next;
                end else begin
                    n_rear = rear_prev;
                end
            end
        end
        n_count_ext = EXT_W'(n_count);
    end

    assign o_sts.pop_pending = !is_push && !is_empty;

    // Input beat latch; payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_opcode'(i_opcode);
            r_val <= i_push_value;
        end
    end

    // Entry store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (wr_en) begin
                r_mem[wr_addr] <= r_val;
            end
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_rear  <= n_rear;
            r_count <= n_count;
        end
    end

    // Result register; the count field keeps its low bits only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_out_count <= n_count_ext[COUNT_W-1:0];
            r_pop_value <= '0;
        end else if (i_cmd.capture) begin
            r_pop_value <= r_rd_data;
        end
    end

    assign o_status      = r_status;
    assign o_pop_value   = r_pop_value;
    assign o_entry_count = r_out_count;

    `CDQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "entry count above depth")
    `CDQ_ASSERT(a_empty_home, i_clk, i_rst_n, (r_count == '0) |-> (r_front == '0 && r_rear == '0), "empty queue with indices away from zero")
    `CDQ_ASSERT(a_push_grows, i_clk, i_rst_n, (i_cmd.exec && is_push && !is_full) |=> (r_count == $past(r_count) + CNT_W'(1)), "successful push did not add an entry")
    `CDQ_ASSERT(a_cmd_excl, i_clk, i_rst_n, !(i_cmd.exec && i_cmd.capture), "execute and capture in one cycle")

endmodule

// ===== hw/rtl/circular_deque.sv =====
// Top level of the circular deque: controller plus datapath behind two channels.
// Depends on cdq_pkg, cdq_in_if, cdq_out_if, cdq_ctrl and cdq_dp.
//
//  Channel  Direction  Beat fields                          Handshake
//  i_in     in         opcode, push_value                   valid/ready
//  o_out    out        status, pop_value, entry_count       valid/ready
//
// One operation is in flight at a time. An accepted beat is executed in the
// next cycle and its result is then offered in S_SEND; a pop that succeeds
// first passes through S_FIN to capture the read data, because the entry
// store has a single registered read port.
// Reset is synchronous and active low; it empties the queue and drops any
// pending result. Entries themselves are never cleared: an entry reaches the
// result only after a push has written it.
// While o_out is stalled the result register holds and i_in stays not ready.
module circular_deque #(
    parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdq_in_if.sink    i_in,
    cdq_out_if.source o_out
);
    import cdq_pkg::*;

    // Command and status bundles between the controller and the datapath.
    t_cdq_cmd cmd;
    t_cdq_sts sts;

    // The controller owns both handshakes and the operation sequence.
    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // The datapath holds the queue and builds the result beat.
    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_in.opcode),
        .i_push_value  (i_in.push_value),
        .o_status      (o_out.status),
        .o_pop_value   (o_out.pop_value),
        .o_entry_count (o_out.entry_count)
    );

endmodule

// ===== tb/tb_circular_deque.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the circular deque: a directed table, then biased random traffic.
// Depends on cdq_pkg, cdq_in_if, cdq_out_if and the circular_deque RTL.
module tb_circular_deque;
    import cdq_pkg::*;

    localparam int unsigned DEPTH        = DEPTH_DEF;
    localparam int unsigned IDX_W        = $clog2(DEPTH);
    localparam int unsigned RANDOM_BEATS = 1250;
    // Cycles with no beat on either channel before the run is declared hung.
    // A correct run never goes past its gap and stall cycles plus the work of
    // one operation, so this is far above the slowest case.
    localparam int unsigned HANG_LIMIT   = 2000;
    // Cycles watched after the last result for anything extra coming out.
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned IDLE_PCT     = 38;
    localparam int unsigned DIRECTED_ROWS = 24;

    // One result beat as the block should present it.
    typedef struct packed {
        t_status             status;
        logic [VALUE_W-1:0]  pop_value;
        logic [COUNT_W-1:0]  entry_count;
    } t_deque_result;

    // One row of the directed table. When has_literal is set, the result is
    // typed into the table; otherwise it comes from the deque predictor.
    typedef struct {
        t_opcode             op;
        logic [VALUE_W-1:0]  value;
        bit                  has_literal;
        t_deque_result       literal;
    } t_stim_row;

    logic clk;
    logic rst_n;
    logic burst_mode;

    cdq_in_if  in_ch ();
    cdq_out_if out_ch ();

    circular_deque #(
        .DEPTH (DEPTH)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Deque predictor. It holds its own copy of the store, the two wrapping
    // indices and the empty flag, and is advanced once per accepted input
    // beat, in acceptance order.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] shadow_store [DEPTH];
    logic [IDX_W-1:0]   shadow_front;
    logic [IDX_W-1:0]   shadow_rear;
    logic               shadow_empty;

    t_deque_result      pending_results [$];
    int unsigned        error_count;

    function automatic logic [IDX_W-1:0] idx_after(logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_before(logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    function automatic t_deque_result apply_deque_op(t_opcode op, logic [VALUE_W-1:0] val);
        t_deque_result res;
        logic          full;
        logic [IDX_W-1:0] at;
        int unsigned   held;
        res  = '{status: ST_DONE, pop_value: '0, entry_count: '0};
        full = !shadow_empty && (idx_after(shadow_rear) == shadow_front);
        if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) begin
            if (full) begin
                res.status = ST_OVERFLOW;
            end else if (shadow_empty) begin
                // The first entry always lands at slot zero.
                shadow_front    = '0;
                shadow_rear     = '0;
                shadow_store[0] = val;
                shadow_empty    = 1'b0;
            end else if (op == OP_PUSH_REAR) begin
                shadow_rear               = idx_after(shadow_rear);
                shadow_store[shadow_rear] = val;
            end else begin
                shadow_front               = idx_before(shadow_front);
                shadow_store[shadow_front] = val;
            end
        end else begin
            if (shadow_empty) begin
                res.status = ST_UNDERFLOW;
            end else begin
                at            = (op == OP_POP_FRONT) ? shadow_front : shadow_rear;
                res.pop_value = shadow_store[at];
                if (shadow_front == shadow_rear) begin
                    // Removing the last entry resets both indices.
                    shadow_front = '0;
                    shadow_rear  = '0;
                    shadow_empty = 1'b1;
                end else if (op == OP_POP_FRONT) begin
                    shadow_front = idx_after(shadow_front);
                end else begin
                    shadow_rear = idx_before(shadow_rear);
                end
            end
        end
        held = shadow_empty ? 0
                            : ((int'(shadow_rear) + DEPTH - int'(shadow_front)) % DEPTH) + 1;
        res.entry_count = COUNT_W'(held);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input side. The task is entered just after a rising edge, at which
    // the previous beat (if any) was accepted. It may leave valid low for a
    // few cycles, then presents the beat and holds it until ready is seen
    // at an edge. Exactly one assignment to valid happens per time step:
    // either the gap lowers it or the new beat keeps it high.
    // ------------------------------------------------------------------
    task automatic send_beat(input t_opcode op, input logic [VALUE_W-1:0] val,
                             input bit has_literal, input t_deque_result literal);
        t_deque_result predicted;
        while (!burst_mode && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.push_value <= val;
        do @(posedge clk); while (!in_ch.ready);
        // The predictor always advances, so that its state stays in step
        // with the block even on rows whose result is typed in.
        predicted = apply_deque_op(op, val);
        pending_results.push_back(has_literal ? literal : predicted);
    endtask

    // Push values lean toward the sign boundary and the all-zero and
    // all-one patterns now and then; otherwise they are uniform.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return {1'b0, {(VALUE_W-1){1'b1}}};
            3:       return {1'b1, {(VALUE_W-1){1'b0}}};
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side. Ready is redrawn at every edge, except in the burst
    // stretch where it stays high so that back-to-back beats are seen.
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= burst_mode ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge clk) begin
        t_deque_result want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d value %h count %0d",
                         $time, out_ch.status, out_ch.pop_value, out_ch.entry_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, out_ch.status);
                    error_count++;
                end
                if (out_ch.pop_value !== want.pop_value) begin
                    $display("%0t: pop_value mismatch, expected %h, got %h",
                             $time, want.pop_value, out_ch.pop_value);
                    error_count++;
                end
                if (out_ch.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count mismatch, expected %0d, got %0d",
                             $time, want.entry_count, out_ch.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Hang detection: count cycles in which no beat moves on either side.
    int unsigned quiet_cycles;
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, HANG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table. It walks the queue from empty to full and back,
    // with both ends used so that the indices wrap, and covers popping on
    // empty, pushing on full, removing the last entry and a push into an
    // empty queue that lands at slot zero again.
    // ------------------------------------------------------------------
    t_stim_row directed_rows [DIRECTED_ROWS];

    initial begin
        t_deque_result none;
        t_opcode       op;
        int unsigned   push_pct;
        none        = '{status: ST_DONE, pop_value: '0, entry_count: '0};
        error_count = 0;
        quiet_cycles = 0;
        burst_mode  <= 1'b0;

        shadow_front = '0;
        shadow_rear  = '0;
        shadow_empty = 1'b1;

        directed_rows = '{
            // Popping either end straight after reset underflows.
            '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_UNDERFLOW, 32'h0, 4'd0}},
            '{OP_POP_REAR,   32'hFFFF_FFFF, 1'b1, '{ST_UNDERFLOW, 32'h0, 4'd0}},
            // Fill from both ends with the extreme values.
            '{OP_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, '{ST_DONE, 32'h0, 4'd1}},
            '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{ST_DONE, 32'h0, 4'd2}},
            '{OP_PUSH_REAR,  32'hFFFF_FFFF, 1'b1, '{ST_DONE, 32'h0, 4'd3}},
            '{OP_PUSH_FRONT, 32'h0000_0000, 1'b1, '{ST_DONE, 32'h0, 4'd4}},
            '{OP_PUSH_REAR,  32'h5555_5555, 1'b0, none},
            '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, none},
            '{OP_PUSH_REAR,  32'h0000_0001, 1'b0, none},
            '{OP_PUSH_FRONT, 32'h1234_5678, 1'b0, none},
            // A full queue refuses pushes at either end.
            '{OP_PUSH_REAR,  32'hDEAD_BEEF, 1'b1, '{ST_OVERFLOW, 32'h0, 4'd8}},
            '{OP_PUSH_FRONT, 32'hCAFE_F00D, 1'b1, '{ST_OVERFLOW, 32'h0, 4'd8}},
            // Drain it, alternating ends, down to the last entry.
            '{OP_POP_FRONT,  32'hFFFF_FFFF, 1'b0, none},
            '{OP_POP_REAR,   32'h0000_0000, 1'b0, none},
            '{OP_POP_FRONT,  32'hA5A5_A5A5, 1'b0, none},
            '{OP_POP_REAR,   32'h5A5A_5A5A, 1'b0, none},
            '{OP_POP_FRONT,  32'h0000_0000, 1'b0, none},
            '{OP_POP_REAR,   32'h0000_0000, 1'b0, none},
            '{OP_POP_FRONT,  32'h0000_0000, 1'b0, none},
            '{OP_POP_REAR,   32'h0000_0000, 1'b0, none},
            '{OP_POP_REAR,   32'h0000_0000, 1'b1, '{ST_UNDERFLOW, 32'h0, 4'd0}},
            // A front push into the empty queue, then take it from the rear.
            '{OP_PUSH_FRONT, 32'h0F0F_0F0F, 1'b1, '{ST_DONE, 32'h0, 4'd1}},
            '{OP_POP_REAR,   32'h0000_0000, 1'b1, '{ST_DONE, 32'h0F0F_0F0F, 4'd0}},
            '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_UNDERFLOW, 32'h0, 4'd0}}
        };

        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.opcode     <= OP_PUSH_REAR;
        in_ch.push_value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_beat(directed_rows[r].op, directed_rows[r].value,
                      directed_rows[r].has_literal, directed_rows[r].literal);
        end

        // Random traffic in short phases, each with its own push bias, so
        // that the queue keeps swinging between full and empty and both
        // boundary cases recur many times. One stretch runs with no gaps
        // on either side.
        push_pct = 50;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 32 == 0) begin
                push_pct = $urandom_range(15, 85);
            end
            if (n == 400) begin
                burst_mode <= 1'b1;
            end else if (n == 650) begin
                burst_mode <= 1'b0;
            end
            if ($urandom_range(0, 99) < push_pct) begin
                op = ($urandom_range(0, 1) == 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            end else begin
                op = ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_REAR;
            end
            send_beat(op, pick_value(), 1'b0, none);
        end
        in_ch.valid <= 1'b0;

        // Let every outstanding result arrive, then watch a little longer
        // for anything the block should not produce.
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_in_if.sv
hw/rtl/cdq_out_if.sv
hw/rtl/cdq_ctrl.sv
hw/rtl/cdq_dp.sv
hw/rtl/circular_deque.sv
tb/tb_circular_deque.sv
